### sv/imgrel_pkg.sv
// Shared types and constants for the image relocation fixup unit.
// Used by imgrel_calc, image_relocation_fixup_unit and imgrel_chk; no dependencies.
package imgrel_pkg;

  // Default address width that target addresses wrap at.
  localparam int unsigned ADDR_WIDTH_DEF = 48;

  // Field widths of the stream items.
  localparam int unsigned WORD_W       = 16;
  localparam int unsigned ADDR_FIELD_W = 48;
  localparam int unsigned VALUE_W      = 64;
  localparam int unsigned OFFSET_W     = 12;
  localparam int unsigned IN_TDATA_W   = WORD_W + ADDR_FIELD_W + VALUE_W;   // 128
  localparam int unsigned OUT_PACKED_W = ADDR_FIELD_W + VALUE_W + 2 + 1;    // 115
  localparam int unsigned OUT_TDATA_W  = ((OUT_PACKED_W + 7) / 8) * 8;      // 120

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 64;
  localparam logic [CFG_IDX_W-1:0] CFG_LOAD_DELTA  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ARM64_ENABLE = 1'b1;

  // Instruction masks for the ARM64 fixups.
  localparam logic [31:0] ADRP_KEEP_MASK  = 32'h9F00001F;
  localparam logic [31:0] IMM12_KEEP_MASK = 32'hFFC003FF;
  localparam logic [31:0] LDST_SEL_MASK   = 32'h3B000000;
  localparam logic [31:0] LDST_SEL_MATCH  = 32'h39000000;

  // Fixup types carried in bits 15:12 of the entry word.
  typedef enum logic [3:0] {
    FIX_ABSOLUTE  = 4'd0,
    FIX_HIGH      = 4'd1,
    FIX_LOW       = 4'd2,
    FIX_HIGHLOW   = 4'd3,
    FIX_DIR64     = 4'd10,
    FIX_ARM_PAGE  = 4'd11,
    FIX_ARM_PGOFF = 4'd12
  } fix_type_e;

  // Write sizes of a patch.
  typedef enum logic [1:0] {
    WSIZE_NONE = 2'd0,
    WSIZE_16   = 2'd1,
    WSIZE_32   = 2'd2,
    WSIZE_64   = 2'd3
  } wsize_e;

  // One computed patch.
  typedef struct packed {
    logic                    err;
    wsize_e                  size;
    logic [VALUE_W-1:0]      value;
    logic [ADDR_FIELD_W-1:0] target;
  } fix_res_t;

endpackage

### sv/imgrel_calc.sv
// Combinational patch computation for one relocation entry.
// Depends on imgrel_pkg.
module imgrel_calc #(
  parameter int unsigned ADDR_WIDTH = imgrel_pkg::ADDR_WIDTH_DEF
) (
  input  logic [imgrel_pkg::WORD_W-1:0]       entry_word_i,
  input  logic [imgrel_pkg::ADDR_FIELD_W-1:0] page_address_i,
  input  logic [imgrel_pkg::VALUE_W-1:0]      old_value_i,
  input  logic [imgrel_pkg::CFG_DATA_W-1:0]   load_delta_i,
  input  logic                                arm64_enable_i,
  output imgrel_pkg::fix_res_t                res_o
);
  import imgrel_pkg::*;

  // Target addresses wrap at ADDR_WIDTH bits, then at the 48-bit field.
  localparam logic [ADDR_FIELD_W-1:0] AddrMask =
    (ADDR_WIDTH >= ADDR_FIELD_W) ? {ADDR_FIELD_W{1'b1}} :
    ADDR_FIELD_W'((64'd1 << ADDR_WIDTH) - 64'd1);

  logic [ADDR_FIELD_W-1:0] target;
  logic [31:0]             insn;
  logic [20:0]             page_imm;
  logic [20:0]             page_new;
  logic [31:0]             adrp_val;
  logic [11:0]             imm12;
  logic [1:0]              scale;
  logic                    ldst;
  logic [11:0]             imm_bytes;
  logic [11:0]             bytes_sum;
  logic [11:0]             imm_new;
  logic [31:0]             pgoff_val;
  fix_type_e               ftype;

  assign target = (page_address_i +
                   {{(ADDR_FIELD_W-OFFSET_W){1'b0}}, entry_word_i[OFFSET_W-1:0]}) & AddrMask;
  assign insn   = old_value_i[31:0];
  assign ftype  = fix_type_e'(entry_word_i[15:12]);

  // ADRP: 21-bit page immediate plus the delta's page number.
  assign page_imm = {insn[23:5], insn[30:29]};
  assign page_new = page_imm + load_delta_i[32:12];
  assign adrp_val = (insn & ADRP_KEEP_MASK) |
                    {1'b0, page_new[1:0], 5'b0, page_new[20:2], 5'b0};

  // 12-bit immediate, scaled by the access size for loads and stores.
  assign imm12     = insn[21:10];
  assign scale     = insn[31:30];
  assign ldst      = (insn & LDST_SEL_MASK) == LDST_SEL_MATCH;
  assign imm_bytes = ldst ? (imm12 << scale) : imm12;
  assign bytes_sum = imm_bytes + load_delta_i[11:0];
  assign imm_new   = ldst ? (bytes_sum >> scale) : bytes_sum;
  assign pgoff_val = (insn & IMM12_KEEP_MASK) | {10'b0, imm_new, 10'b0};

  always_comb begin
    res_o        = '0;
    res_o.target = target;
    res_o.size   = WSIZE_NONE;
    unique case (ftype)
      FIX_ABSOLUTE: begin
        res_o.size = WSIZE_NONE;
      end
      FIX_HIGH: begin
        res_o.value = {48'b0, old_value_i[15:0] + load_delta_i[31:16]};
        res_o.size  = WSIZE_16;
      end
      FIX_LOW: begin
        res_o.value = {48'b0, old_value_i[15:0] + load_delta_i[15:0]};
        res_o.size  = WSIZE_16;
      end
      FIX_HIGHLOW: begin
        res_o.value = {32'b0, old_value_i[31:0] + load_delta_i[31:0]};
        res_o.size  = WSIZE_32;
      end
      FIX_DIR64: begin
        res_o.value = old_value_i + load_delta_i;
        res_o.size  = WSIZE_64;
      end
      FIX_ARM_PAGE: begin
        if (arm64_enable_i) begin
          res_o.value = {32'b0, adrp_val};
          res_o.size  = WSIZE_32;
        end else begin
          res_o.err = 1'b1;
        end
      end
      FIX_ARM_PGOFF: begin
        if (arm64_enable_i) begin
          res_o.value = {32'b0, pgoff_val};
          res_o.size  = WSIZE_32;
        end else begin
          res_o.err = 1'b1;
        end
      end
      default: begin
        res_o.err = 1'b1;
      end
    endcase
  end

endmodule

### sv/image_relocation_fixup_unit.sv
// Top level of the image relocation fixup unit: input register, patch logic, result register.
// Depends on imgrel_pkg and imgrel_calc.
//
// The unit patches one base-relocation entry per beat. A slave stream carries the
// entry word, the page address of its block and the current contents at the target;
// tlast marks the last entry of a block and comes back unchanged on the master side.
// Each result beat gives the target address, the patched value, the write size and an
// error flag. The caller should stop at the first beat whose error flag is set.
// The user must set the load delta and the ARM64 enable through the write port before a
// run, while no beat is in flight; the block itself does not enforce this.
//
// Timing: an accepted beat sits in the input register, passes the patch logic and is
// captured in the result register, from which it is offered on the master side. Both
// registers forward independently, so one beat is accepted per cycle when the receiver
// keeps up; the patch logic between the two registers sets the cycle time.
// When the receiver stalls, the result register holds its beat, the input register
// still takes one more beat, and tready falls only once both are full.
// Reset clears both valid flags and sets the delta and the ARM64 enable to zero.
module image_relocation_fixup_unit #(
  parameter int unsigned ADDR_WIDTH = imgrel_pkg::ADDR_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write port.
  input  logic                                cfg_we_i,
  input  logic [imgrel_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [imgrel_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // Entry stream.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata from bit 0: entry_word[15:0], page_address[63:16], old_value[127:64]
  input  logic [imgrel_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  input  logic                                s_axis_tlast,   // last_in_block
  // Patch stream.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata from bit 0: target_address[47:0], new_value[111:48], write_size[113:112],
  // fixup_error[114], zero padding[119:115]
  output logic [imgrel_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  output logic                                m_axis_tlast    // block_done
);
  import imgrel_pkg::*;

  logic [CFG_DATA_W-1:0]   load_delta_q;
  logic                    arm64_enable_q;

  logic                    in_vld_q;
  logic [WORD_W-1:0]       in_word_q;
  logic [ADDR_FIELD_W-1:0] in_page_q;
  logic [VALUE_W-1:0]      in_old_q;
  logic                    in_last_q;

  logic                    out_vld_q;
  fix_res_t                out_res_q;
  logic                    out_last_q;

  fix_res_t                calc_res;
  logic                    out_ready;
  logic                    in_load;
  logic                    out_load;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_delta_q   <= '0;
      arm64_enable_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LOAD_DELTA:   load_delta_q   <= cfg_data_i;
        CFG_ARM64_ENABLE: arm64_enable_q <= cfg_data_i[0];
        default:          ;
      endcase
    end
  end

  // The result register frees up when empty or when its beat is taken; the input
  // register frees up when empty or when its beat moves on.
  assign out_ready     = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !in_vld_q || out_ready;
  assign in_load       = s_axis_tvalid && s_axis_tready;
  assign out_load      = in_vld_q && out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (out_ready) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_word_q <= s_axis_tdata[WORD_W-1:0];
      in_page_q <= s_axis_tdata[WORD_W+ADDR_FIELD_W-1:WORD_W];
      in_old_q  <= s_axis_tdata[IN_TDATA_W-1:WORD_W+ADDR_FIELD_W];
      in_last_q <= s_axis_tlast;
    end
    if (out_load) begin
      out_res_q  <= calc_res;
      out_last_q <= in_last_q;
    end
  end

  imgrel_calc #(
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_calc (
    .entry_word_i   (in_word_q),
    .page_address_i (in_page_q),
    .old_value_i    (in_old_q),
    .load_delta_i   (load_delta_q),
    .arm64_enable_i (arm64_enable_q),
    .res_o          (calc_res)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W-OUT_PACKED_W){1'b0}}, out_res_q.err,
                          out_res_q.size, out_res_q.value, out_res_q.target};

endmodule

### sv/imgrel_chk.sv
// Port-level checker for image_relocation_fixup_unit, attached by the bind below.
// Depends on imgrel_pkg.
module imgrel_chk (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [imgrel_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                               m_axis_tlast
);
  import imgrel_pkg::*;

  logic [1:0]  size;
  logic        err;
  logic [63:0] value;

  assign value = m_axis_tdata[111:48];
  assign size  = m_axis_tdata[113:112];
  assign err   = m_axis_tdata[114];

  // A stalled result beat stays offered.
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its payload.
  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result beat changed while stalled");

  // An error never comes with a write.
  a_err_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && err |-> size == WSIZE_NONE && value == '0)
    else $error("error beat carries a write");

  // The patched value stays within the bits its write size covers.
  a_value_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (size == WSIZE_64) ||
      (size == WSIZE_32 && value[63:32] == '0) ||
      (size == WSIZE_16 && value[63:16] == '0) ||
      (size == WSIZE_NONE && value == '0))
    else $error("patched value wider than its write size");

endmodule

bind image_relocation_fixup_unit imgrel_chk u_imgrel_chk (.*);
